// ----- rtl/core/spq_pkg.sv -----
// Package for the sorted priority queue: transaction payload types, operation
// and status codes, and the controller-to-datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
        logic [7:0]         rank;
    } t_spq_in;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic [7:0]         head_rank;
        logic               is_empty;
        logic [4:0]         fill_count;
        logic [1:0]         status;
    } t_spq_out;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_spq_cmd;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
// Controller for the sorted priority queue: sequences capture, execution and
// result reporting, and owns the output valid flag. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_spq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = i_in_valid && (r_state == S_IDLE);
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_REPORT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/spq_datapath.sv -----
// Datapath for the sorted priority queue: input register, a row of sorted
// cells that shift on insert and remove, the entry count and the result
// register. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_spq_cmd i_cmd,
    input  t_spq_in  i_in_data,
    output t_spq_out o_out_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_spq_in            r_in;
    logic signed [31:0] r_val  [QUEUE_DEPTH];
    logic [7:0]         r_rank [QUEUE_DEPTH];
    logic [CW-1:0]      r_count;
    logic [1:0]         r_status;
    t_spq_out           r_out;

    logic [QUEUE_DEPTH-1:0] keep;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_push;
    logic                   do_pop;

    assign is_full  = (r_count == CW'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);
    assign do_push  = i_cmd.exec && (r_in.op == OP_PUSH) && !is_full;
    assign do_pop   = i_cmd.exec && (r_in.op == OP_POP) && !is_empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign keep[g] = (CW'(g) < r_count) && (r_rank[g] <= r_in.rank);

        always_ff @(posedge i_clk) begin
            if (do_push && !keep[g]) begin
                if (g == 0) begin
                    r_val[g]  <= r_in.value;
                    r_rank[g] <= r_in.rank;
                end else if (keep[(g == 0) ? 0 : g - 1]) begin
                    r_val[g]  <= r_in.value;
                    r_rank[g] <= r_in.rank;
                end else begin
                    r_val[g]  <= r_val[(g == 0) ? 0 : g - 1];
                    r_rank[g] <= r_rank[(g == 0) ? 0 : g - 1];
                end
            end else if (do_pop && (g < QUEUE_DEPTH - 1)) begin
                r_val[g]  <= r_val[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                r_rank[g] <= r_rank[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_push) begin
            r_count <= r_count + CW'(1);
        end else if (do_pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if ((r_in.op == OP_PUSH) && is_full) begin
                r_status <= ST_FULL;
            end else if ((r_in.op == OP_POP) && is_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.head_value <= is_empty ? 32'sd0 : r_val[0];
            r_out.head_rank  <= is_empty ? 8'd0 : r_rank[0];
            r_out.is_empty   <= is_empty;
            r_out.fill_count <= 5'(r_count);
            r_out.status     <= r_status;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: joins the controller and the
// datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   Channel   Direction   Handshake                  Payload
//   input     in          i_in_valid / o_in_ready    i_in_data  (t_spq_in)
//   result    out         o_out_valid / i_out_ready  o_out_data (t_spq_out)
//
// Each transaction passes through capture, an execution step in which the whole
// row of cells shifts in parallel, and loading of the result register.
// A new transaction is taken while the previous result still waits.
// A stalled result holds the controller in its reporting state only.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_spq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_spq_out o_out_data
);

    t_spq_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// ----- rtl/core/spq_checker.sv -----
// Port-level checker for the sorted priority queue, with its bind statement.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_spq_out o_out_data
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |->
            (o_out_data.fill_count == 5'd0 && o_out_data.head_rank == 8'd0 &&
             o_out_data.head_value == 32'sd0))
        else $error("Empty result carries a head entry.");

    a_pop_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |-> o_out_data.is_empty)
        else $error("Pop from empty reported with entries held.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Transaction taken while another is in progress.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("Stalled result changed.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
